[rtl/cpa_pkg.sv]
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types, constants and the root table of the power activation unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpa_pkg;

	localparam int CHANNELS = 64;
	localparam int CH_W     = 6;

	localparam logic [15:0] EXP_ONE  = 16'd4096;
	localparam logic [31:0] LN2_Q32  = 32'd2977044472;

	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0,
		MODE_FWD  = 2'd1,
		MODE_BWD  = 2'd2,
		MODE_READ = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t        mode;
		logic [31:0]  x;
		logic [31:0]  g;
		logic [31:0]  y;
		logic [15:0]  p;
		logic [47:0]  sum;
	} cpa_cmd_t;

	typedef struct packed {
		logic [31:0]  result;
		logic [47:0]  grad_sum;
		logic         dom;
		logic         sum_we;
		logic [47:0]  sum_new;
	} cpa_rsp_t;

	typedef logic [31:0] root_tab_t [0:24];

	function automatic logic [31:0] isqrt_c(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] bit_v;
		logic [63:0] rem;
		r     = '0;
		bit_v = 64'd1 << 62;
		rem   = v;
		for (int k = 0; k < 32; k++) begin
			if (rem >= r + bit_v) begin
				rem = rem - (r + bit_v);
				r   = (r >> 1) + bit_v;
			end else begin
				r = r >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return r[31:0];
	endfunction

	// 2^(2^-i) in Q2.30, each a floor square root of the one before
	function automatic root_tab_t build_roots();
		root_tab_t t;
		t[0] = 32'h8000_0000;
		for (int i = 1; i <= 24; i++) begin
			t[i] = isqrt_c({t[i-1], 30'd0} >> 0);
		end
		return t;
	endfunction

	localparam root_tab_t ROOT_TAB = build_roots();

endpackage

`default_nettype wire

[rtl/cpa_mem.sv]
// ----------------------------------------------------------------------------
// cpa_mem
// Exponent table and gradient accumulators, with a registered synchronous read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpa_mem (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    clear,
	input  wire logic                    rd_en,
	input  wire logic [cpa_pkg::CH_W-1:0] ch,
	input  wire logic                    exp_we,
	input  wire logic [15:0]             exp_wdata,
	input  wire logic                    sum_we,
	input  wire logic [47:0]             sum_wdata,
	output logic      [15:0]             rd_exp,
	output logic      [47:0]             rd_sum
);

	logic [15:0] exp_mem [cpa_pkg::CHANNELS];
	logic [47:0] sum_mem [cpa_pkg::CHANNELS];
	logic [cpa_pkg::CHANNELS-1:0] exp_vld_q;
	logic [cpa_pkg::CHANNELS-1:0] sum_vld_q;
	logic [15:0] exp_rd_q;
	logic [47:0] sum_rd_q;
	logic        exp_rv_q;
	logic        sum_rv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_vld_q <= '0;
			sum_vld_q <= '0;
		end else begin
			if (exp_we)
				exp_vld_q[ch] <= 1'b1;
			if (clear)
				sum_vld_q <= '0;
			else if (sum_we)
				sum_vld_q[ch] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (exp_we)
			exp_mem[ch] <= exp_wdata;
		if (sum_we)
			sum_mem[ch] <= sum_wdata;
		if (rd_en) begin
			exp_rd_q <= exp_mem[ch];
			sum_rd_q <= sum_mem[ch];
			exp_rv_q <= exp_vld_q[ch];
			sum_rv_q <= sum_vld_q[ch];
		end
	end

	// entries never written read as their reset value
	assign rd_exp = exp_rv_q ? exp_rd_q : cpa_pkg::EXP_ONE;
	assign rd_sum = sum_rv_q ? sum_rd_q : '0;

endmodule

`default_nettype wire

[rtl/cpa_math.sv]
// ----------------------------------------------------------------------------
// cpa_math
// Sequenced arithmetic: log2, exp2, long division and gradient terms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpa_math (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire cpa_pkg::cpa_cmd_t cmd,
	output logic                   done,
	output cpa_pkg::cpa_rsp_t      rsp
);

	typedef enum logic [11:0] {
		M_IDLE = 12'b000000000001,
		M_LOG  = 12'b000000000010,
		M_POWT = 12'b000000000100,
		M_EXP  = 12'b000000001000,
		M_GY   = 12'b000000010000,
		M_DIV  = 12'b000000100000,
		M_MAG  = 12'b000001000000,
		M_LN   = 12'b000010000000,
		M_HI   = 12'b000100000000,
		M_LO   = 12'b001000000000,
		M_ACC  = 12'b010000000000,
		M_DONE = 12'b100000000000
	} mstate_t;

	mstate_t state_q, state_d;
	logic [5:0] cnt_q, cnt_d;

	cpa_pkg::mode_t mode_q;
	logic [30:0]  x_q;
	logic signed [31:0] g_q, y_q;
	logic signed [15:0] p_q;
	logic signed [47:0] sum_q;
	logic [4:0]   e_q;
	logic [30:0]  m_q;
	logic [23:0]  frac_q;
	logic signed [9:0] n_q;
	logic [23:0]  f_q;
	logic [31:0]  acc_q;
	logic         gneg_q;
	logic [62:0]  a_q;
	logic [30:0]  rem_q;
	logic [62:0]  dvd_q;
	logic [28:0]  b_q;
	logic         lneg_q;
	logic [59:0]  hi_q;
	logic [52:0]  tm_q;
	cpa_pkg::cpa_rsp_t rsp_q;

	// combinational terms
	logic [4:0]   e_nrm;
	logic signed [5:0]  e_m16;
	logic signed [29:0] l_val;
	logic [61:0]  sq;
	logic [31:0]  sq_s;
	logic signed [45:0] pl;
	logic signed [33:0] t_v;
	logic signed [9:0]  n_v;
	logic [63:0]  ap_prod;
	logic [31:0]  acc_nxt;
	logic [4:0]   sh;
	logic signed [63:0] gy;
	logic [63:0]  gy_abs;
	logic [31:0]  trial;
	logic         ge;
	logic [15:0]  ap;
	logic [63:0]  qp;
	logic [51:0]  mag;
	logic         neg;
	logic signed [61:0] lp;
	logic signed [29:0] lnx;
	logic [29:0]  lnx_abs;
	logic [60:0]  lo;
	logic [60:0]  tsum;
	logic signed [54:0] term;
	logic signed [54:0] s_v;
	logic [47:0]  s_sat;

	always_comb begin
		e_nrm = '0;
		for (int k = 0; k < 31; k++)
			if (cmd.x[k])
				e_nrm = 5'(k);
	end

	always_comb begin
		e_m16   = $signed({1'b0, e_q}) - 6'sd16;
		l_val   = {e_m16, frac_q};
		sq      = 62'(m_q) * 62'(m_q);
		sq_s    = sq[61:30];
		pl      = 46'(p_q) * 46'(l_val);
		t_v     = pl[45:12];
		n_v     = t_v[33:24];
		ap_prod = 64'(acc_q) * 64'(cpa_pkg::ROOT_TAB[5'(cnt_q) + 5'd1]);
		acc_nxt = f_q[23] ? ap_prod[61:30] : acc_q;
		sh      = 5'(10'sd14 - n_q);
		gy      = 64'(g_q) * 64'(y_q);
		gy_abs  = gy[63] ? 64'(-gy) : 64'(gy);
		trial   = {rem_q, dvd_q[62]};
		ge      = trial >= {1'b0, x_q};
		ap      = p_q[15] ? 16'(-p_q) : 16'(p_q);
		qp      = 64'(dvd_q[47:0]) * 64'(ap);
		mag     = qp[63:12];
		neg     = gneg_q ^ p_q[15];
		lp      = 62'(l_val) * $signed({30'd0, cpa_pkg::LN2_Q32});
		lnx     = lp[61:32];
		lnx_abs = lnx[29] ? 30'(-lnx) : 30'(lnx);
		lo      = 61'(a_q[31:0]) * 61'(b_q);
		tsum    = 61'(hi_q) + 61'(lo[60:32]);
		term    = (gneg_q ^ lneg_q) ? -$signed({2'b00, tm_q}) : $signed({2'b00, tm_q});
		s_v     = 55'(sum_q) + term;
		if (s_v > 55'sh7FFF_FFFF_FFFF)
			s_sat = 48'h7FFF_FFFF_FFFF;
		else if (s_v < -55'sh8000_0000_0000)
			s_sat = 48'h8000_0000_0000;
		else
			s_sat = s_v[47:0];
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			M_IDLE: begin
				cnt_d = '0;
				if (start) begin
					if (cmd.mode == cpa_pkg::MODE_LOAD || cmd.mode == cpa_pkg::MODE_READ)
						state_d = M_DONE;
					else if (cmd.x[31] || cmd.x == '0)
						state_d = M_DONE;
					else
						state_d = M_LOG;
				end
			end
			M_LOG: begin
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd23) begin
					cnt_d   = '0;
					state_d = (mode_q == cpa_pkg::MODE_FWD) ? M_POWT : M_GY;
				end
			end
			M_POWT: begin
				if (n_v >= 10'sd15 || n_v < -10'sd17)
					state_d = M_DONE;
				else
					state_d = M_EXP;
			end
			M_EXP: begin
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd23)
					state_d = M_DONE;
			end
			M_GY:  state_d = M_DIV;
			M_DIV: begin
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd62)
					state_d = M_MAG;
			end
			M_MAG:  state_d = M_LN;
			M_LN:   state_d = M_HI;
			M_HI:   state_d = M_LO;
			M_LO:   state_d = M_ACC;
			M_ACC:  state_d = M_DONE;
			M_DONE: state_d = M_IDLE;
			default: state_d = M_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (start) begin
					mode_q <= cmd.mode;
					x_q    <= cmd.x[30:0];
					g_q    <= cmd.g;
					y_q    <= cmd.y;
					p_q    <= cmd.p;
					sum_q  <= cmd.sum;
					e_q    <= e_nrm;
					m_q    <= 31'(cmd.x[30:0] << (5'd30 - e_nrm));
					frac_q <= '0;
					rsp_q.result   <= '0;
					rsp_q.grad_sum <= (cmd.mode == cpa_pkg::MODE_READ) ? cmd.sum : '0;
					rsp_q.dom      <= cmd.mode != cpa_pkg::MODE_LOAD &&
						cmd.mode != cpa_pkg::MODE_READ && (cmd.x[31] || cmd.x == '0);
					rsp_q.sum_we   <= 1'b0;
					rsp_q.sum_new  <= '0;
				end
			end
			M_LOG: begin
				// square, renormalize and emit one fraction bit
				if (sq_s[31]) begin
					m_q    <= sq_s[31:1];
					frac_q <= {frac_q[22:0], 1'b1};
				end else begin
					m_q    <= sq_s[30:0];
					frac_q <= {frac_q[22:0], 1'b0};
				end
			end
			M_POWT: begin
				n_q   <= n_v;
				f_q   <= t_v[23:0];
				acc_q <= 32'h4000_0000;
				if (n_v >= 10'sd15)
					rsp_q.result <= 32'h7FFF_FFFF;
			end
			M_EXP: begin
				acc_q <= acc_nxt;
				f_q   <= {f_q[22:0], 1'b0};
				if (cnt_q == 6'd23)
					rsp_q.result <= acc_nxt >> sh;
			end
			M_GY: begin
				gneg_q <= gy[63];
				a_q    <= gy_abs[62:0];
				dvd_q  <= gy_abs[62:0];
				rem_q  <= '0;
			end
			M_DIV: begin
				rem_q <= ge ? 31'(trial - {1'b0, x_q}) : trial[30:0];
				dvd_q <= {dvd_q[61:0], ge};
			end
			M_MAG: begin
				if (ap == '0 || dvd_q == '0)
					rsp_q.result <= '0;
				else if (dvd_q[62:48] != '0 || mag[51:31] != '0)
					rsp_q.result <= neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
				else
					rsp_q.result <= neg ? 32'(-mag[31:0]) : mag[31:0];
			end
			M_LN: begin
				lneg_q <= lnx[29];
				b_q    <= lnx_abs[28:0];
			end
			M_HI: hi_q <= 60'(a_q[62:32]) * 60'(b_q);
			M_LO: tm_q <= tsum[60:8];
			M_ACC: begin
				rsp_q.sum_new <= s_sat;
				rsp_q.sum_we  <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign done = (state_q == M_DONE);
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

[rtl/channel_power_activation_core.sv]
// ----------------------------------------------------------------------------
// channel_power_activation_core
// Power activation element unit with a learned exponent per channel.
// ----------------------------------------------------------------------------
// Usage: items enter on the s_ group (tuser carries the mode) and one result
// beat leaves on the m_ group per item. Load writes a channel's Q4.12
// exponent, forward returns x^p, backward returns the input gradient and
// adds the exponent gradient term to the channel's 48-bit sum, read returns
// that sum. A set clear bit zeroes every sum before the item is handled.
// Forward runs a 24-step log2 and a 24-step exp2, and ends early when the
// power overflows or underflows; backward is set mainly by the 63-step
// bit-serial divider; load, read and x <= 0 skip the arithmetic. One item
// is in work at a time; the next can be accepted in the cycle after the
// result enters the output register.
// Reset sets every exponent to 1.0 and every sum to 0 at once via valid
// bits, with no clearing pass. When the receiver stalls the result holds in
// the output register and the core stops after finishing the next item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module channel_power_activation_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// channel, sample_in, exponent_in, upstream_grad, forward_value,
	// clear_sums, zero pad
	input  wire logic [119:0] s_tdata,
	// mode
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// result, grad_sum
	output logic      [79:0]  m_tdata,
	// domain_error
	output logic              m_tuser
);

	typedef enum logic [4:0] {
		T_IDLE = 5'b00001,
		T_READ = 5'b00010,
		T_RUN  = 5'b00100,
		T_BUSY = 5'b01000,
		T_PUSH = 5'b10000
	} tstate_t;

	tstate_t state_q;
	cpa_pkg::mode_t mode_q;
	logic [cpa_pkg::CH_W-1:0] ch_q;
	logic [31:0] x_q, g_q, y_q;
	logic [15:0] exp_q;
	logic        acc_in;
	logic        m_tvalid_q;
	logic [79:0] m_tdata_q;
	logic        m_tuser_q;
	logic        push;
	logic [15:0] rd_exp;
	logic [47:0] rd_sum;
	logic        done;
	cpa_pkg::cpa_cmd_t cmd;
	cpa_pkg::cpa_rsp_t rsp;

	assign s_tready = (state_q == T_IDLE);
	assign acc_in   = s_tvalid && s_tready;
	assign push     = (state_q == T_PUSH) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				T_IDLE: if (acc_in) state_q <= T_READ;
				T_READ: state_q <= T_RUN;
				T_RUN:  state_q <= T_BUSY;
				T_BUSY: if (done) state_q <= T_PUSH;
				T_PUSH: if (push) state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
			if (push)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			mode_q <= cpa_pkg::mode_t'(s_tuser);
			ch_q   <= s_tdata[5:0];
			x_q    <= s_tdata[37:6];
			exp_q  <= s_tdata[53:38];
			g_q    <= s_tdata[85:54];
			y_q    <= s_tdata[117:86];
		end
		if (push) begin
			m_tdata_q <= {rsp.grad_sum, rsp.result};
			m_tuser_q <= rsp.dom;
		end
	end

	assign cmd = '{mode: mode_q, x: x_q, g: g_q, y: y_q, p: rd_exp, sum: rd_sum};

	cpa_mem u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (acc_in && s_tdata[118]),
		.rd_en     (state_q == T_READ),
		.ch        (ch_q),
		.exp_we    (state_q == T_READ && mode_q == cpa_pkg::MODE_LOAD),
		.exp_wdata (exp_q),
		.sum_we    (done && rsp.sum_we),
		.sum_wdata (rsp.sum_new),
		.rd_exp    (rd_exp),
		.rd_sum    (rd_sum)
	);

	cpa_math u_math (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == T_RUN),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

[bench/tb_channel_power_activation_core.sv]
// ----------------------------------------------------------------------------
// tb_channel_power_activation_core
// Drives mode items through the power activation unit and checks each result
// beat against a bit-exact fixed-point predictor of exponents and sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_channel_power_activation_core;

	typedef struct packed {
		cpa_pkg::mode_t mode;
		logic [5:0]  channel;
		logic [31:0] sample;
		logic [15:0] exponent;
		logic [31:0] upstream;
		logic [31:0] fwd_value;
		logic        clear;
	} act_item_t;

	typedef struct packed {
		logic [31:0] result;
		logic [47:0] grad_sum;
		logic        domain_error;
	} act_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [119:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        m_tuser;

	channel_power_activation_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	act_item_t   pending_items[$];
	act_result_t expected_results[$];
	logic [15:0] exp_table [0:63];
	longint      sum_table [0:63];
	logic [31:0] root_chain [0:24];
	int          errors = 0;
	int          beats_out = 0;
	int          n_fwd = 0, n_bwd = 0, n_dom = 0;
	bit          stim_done = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb_channel_power_activation_core NOT OK");
		$finish;
	end

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint log2_q24(logic [31:0] x);
		int e;
		logic [63:0] m;
		longint frac;
		e = 30;
		frac = 0;
		while (e > 0 && x[e] == 1'b0)
			e--;
		m = 64'(x) << (30 - e);
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return longint'(e - 16) * (longint'(1) << 24) + frac;
	endfunction

	function automatic longint power_q16(logic [31:0] x, longint p);
		longint t, n;
		logic [23:0] f;
		logic [63:0] acc;
		t = shr_floor(p * log2_q24(x), 12);
		n = shr_floor(t, 24);
		f = t[23:0];
		acc = 64'd1 << 30;
		if (n >= 15)
			return 64'h7FFF_FFFF;
		if (n < -17)
			return 0;
		for (int i = 1; i <= 24; i++)
			if (f[24 - i])
				acc = (acc * 64'(root_chain[i])) >> 30;
		return longint'(acc >> (14 - n));
	endfunction

	function automatic logic [63:0] sqrt_floor(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic act_result_t predict_activation(act_item_t it);
		act_result_t r;
		longint x, g, y, p, gy, lnx, term, s;
		logic [63:0] a, ap, q, mag, b, hi, lo;
		bit neg;
		int ch;
		r = '0;
		ch = it.channel;
		x = longint'($signed(it.sample));
		g = longint'($signed(it.upstream));
		y = longint'($signed(it.fwd_value));
		p = longint'($signed(exp_table[ch]));
		if (it.clear)
			for (int i = 0; i < 64; i++)
				sum_table[i] = 0;
		if (it.mode == cpa_pkg::MODE_LOAD) begin
			exp_table[ch] = it.exponent;
		end else if (it.mode == cpa_pkg::MODE_READ) begin
			r.grad_sum = sum_table[ch][47:0];
		end else if (x <= 0) begin
			r.domain_error = 1'b1;
		end else if (it.mode == cpa_pkg::MODE_FWD) begin
			r.result = 32'(power_q16(it.sample, p));
		end else begin
			gy = g * y;
			a = gy < 0 ? -gy : gy;
			neg = (gy < 0) != (p < 0);
			ap = p < 0 ? -p : p;
			q = a / 64'(x);
			if (ap == 0 || q == 0)
				mag = 0;
			else if (q >= (64'd1 << 48))
				mag = 64'd1 << 40;
			else
				mag = (q * ap) >> 12;
			if (neg)
				r.result = mag >= (64'd1 << 31) ? 32'h8000_0000 : -mag[31:0];
			else
				r.result = mag >= (64'd1 << 31) ? 32'h7FFF_FFFF : mag[31:0];
			lnx = shr_floor(log2_q24(it.sample) * longint'(cpa_pkg::LN2_Q32), 32);
			b = lnx < 0 ? -lnx : lnx;
			hi = (a >> 32) * b;
			lo = (a & 64'hFFFF_FFFF) * b;
			term = longint'((hi + (lo >> 32)) >> 8);
			if ((gy < 0) != (lnx < 0))
				term = -term;
			s = sum_table[ch] + term;
			if (s > 64'sd140737488355327)
				s = 64'sd140737488355327;
			if (s < -64'sd140737488355328)
				s = -64'sd140737488355328;
			sum_table[ch] = s;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 50)
			return 0;
		if (k < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 120);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 32'h3_0000);
			1: return 32'h8000_0000 | $urandom;
			2: return 32'h7FFF_FFFF - $urandom_range(0, 15);
			3: return $urandom_range(1, 16);
			default: return $urandom;
		endcase
	endfunction

	function automatic act_item_t rand_item();
		act_item_t it;
		it.mode = cpa_pkg::mode_t'($urandom_range(0, 3));
		if ($urandom_range(0, 9) < 7 && it.mode == cpa_pkg::MODE_LOAD)
			it.mode = cpa_pkg::MODE_BWD;
		it.channel = 6'($urandom_range(0, 63));
		if ($urandom_range(0, 1))
			it.channel = 6'($urandom_range(0, 3));
		it.sample = rand_word();
		if ($urandom_range(0, 3) != 0)
			it.sample = $urandom_range(1, 32'h7FFF_FFFF);
		case ($urandom_range(0, 3))
			0: it.exponent = 16'($urandom);
			1: it.exponent = 16'(int'($urandom_range(0, 16384)) - 8192);
			2: it.exponent = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: it.exponent = 16'(int'($urandom_range(0, 8192)) - 4096);
		endcase
		it.upstream = rand_word();
		it.fwd_value = rand_word();
		it.clear = $urandom_range(0, 49) == 0;
		return it;
	endfunction

	function automatic act_item_t mk(cpa_pkg::mode_t m, int ch, logic [31:0] x,
			logic [15:0] e, logic [31:0] g, logic [31:0] y, logic c);
		act_item_t it;
		it.mode = m;
		it.channel = 6'(ch);
		it.sample = x;
		it.exponent = e;
		it.upstream = g;
		it.fwd_value = y;
		it.clear = c;
		return it;
	endfunction

	// driver
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		act_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			gap_left <= 0;
		end else if (s_tvalid && !s_tready) begin
			// hold the beat
		end else if (gap_left > 0) begin
			s_tvalid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_items.size() > 0) begin
			it = pending_items.pop_front();
			expected_results.push_back(predict_activation(it));
			s_tvalid <= 1'b1;
			s_tuser  <= it.mode;
			s_tdata  <= {1'b0, it.clear, it.fwd_value, it.upstream, it.exponent,
				it.sample, it.channel};
			gap_left <= pick_gap();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		act_result_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				beats_out++;
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (m_tdata[31:0] !== e.result) begin
						$error("result exp %h got %h", e.result, m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[79:32] !== e.grad_sum) begin
						$error("grad_sum exp %h got %h", e.grad_sum, m_tdata[79:32]);
						errors++;
					end
					if (m_tuser !== e.domain_error) begin
						$error("domain_error exp %b got %b", e.domain_error, m_tuser);
						errors++;
					end
				end
			end
			m_tready <= pick_gap() == 0 || $urandom_range(0, 3) == 0;
		end
	end

	initial begin
		act_item_t it;
		arst_n = 0;
		for (int i = 0; i < 64; i++) begin
			exp_table[i] = cpa_pkg::EXP_ONE;
			sum_table[i] = 0;
		end
		root_chain[0] = 32'h8000_0000;
		for (int i = 1; i <= 24; i++)
			root_chain[i] = 32'(sqrt_floor(64'(root_chain[i - 1]) << 30));
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, domain, saturation, zero exponent, clear
		pending_items.push_back(mk(cpa_pkg::MODE_FWD, 0, 32'h0001_0000, 0, 0, 0, 0));
		pending_items.push_back(mk(cpa_pkg::MODE_FWD, 63, 32'h7FFF_FFFF, 0, 0, 0, 0));
		pending_items.push_back(mk(cpa_pkg::MODE_FWD, 1, 32'd0, 0, 0, 0, 0));
		pending_items.push_back(mk(cpa_pkg::MODE_BWD, 1, 32'h8000_0000, 0, 5, 5, 0));
		pending_items.push_back(mk(cpa_pkg::MODE_LOAD, 2, 0, 16'h7FFF, 0, 0, 0));
		pending_items.push_back(mk(cpa_pkg::MODE_FWD, 2, 32'h0010_0000, 0, 0, 0, 0));
		pending_items.push_back(mk(cpa_pkg::MODE_FWD, 2, 32'h0000_1000, 0, 0, 0, 0));
		pending_items.push_back(mk(cpa_pkg::MODE_LOAD, 3, 0, 16'h8000, 0, 0, 0));
		pending_items.push_back(mk(cpa_pkg::MODE_FWD, 3, 32'h0010_0000, 0, 0, 0, 0));
		pending_items.push_back(mk(cpa_pkg::MODE_FWD, 3, 32'd1, 0, 0, 0, 0));
		pending_items.push_back(mk(cpa_pkg::MODE_LOAD, 4, 0, 16'h0000, 0, 0, 0));
		pending_items.push_back(mk(cpa_pkg::MODE_BWD, 4, 32'h0002_0000, 0, 32'h0001_0000,
			32'h0001_0000, 0));
		pending_items.push_back(mk(cpa_pkg::MODE_BWD, 5, 32'd1, 0, 32'h7FFF_FFFF,
			32'h8000_0000, 0));
		pending_items.push_back(mk(cpa_pkg::MODE_BWD, 5, 32'd1, 0, 32'h8000_0000,
			32'h8000_0000, 0));
		for (int i = 0; i < 6; i++)
			pending_items.push_back(mk(cpa_pkg::MODE_BWD, 6, 32'h7FFF_FFFF, 0,
				32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		pending_items.push_back(mk(cpa_pkg::MODE_READ, 6, 0, 0, 0, 0, 0));
		pending_items.push_back(mk(cpa_pkg::MODE_READ, 5, 0, 0, 0, 0, 1));
		pending_items.push_back(mk(cpa_pkg::MODE_READ, 6, 32'hFFFF_FFFF, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));

		for (int i = 0; i < 1850; i++) begin
			it = rand_item();
			pending_items.push_back(it);
			n_fwd += it.mode == cpa_pkg::MODE_FWD;
			n_bwd += it.mode == cpa_pkg::MODE_BWD;
			n_dom += (it.mode inside {cpa_pkg::MODE_FWD, cpa_pkg::MODE_BWD}) &&
				$signed(it.sample) <= 0;
		end

		wait (pending_items.size() == 0 && expected_results.size() == 0);
		repeat (200) @(posedge clk);
		$display("Covered %0d result beats: %0d forward, %0d backward, %0d domain cases",
			beats_out, n_fwd, n_bwd, n_dom);
		$display("with loads, sum reads, clears and random stalls on both streams.");
		if (errors == 0 && expected_results.size() == 0) begin
			$display("tb_channel_power_activation_core OK");
		end else begin
			$display("tb_channel_power_activation_core NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
